### rtl/core/mrpt_pkg.sv
`timescale 1ns / 1ps
package mrpt_pkg;

  localparam int unsigned CandWidth = 32;
  localparam int unsigned NumWitnesses = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMALL,
    ST_SPLIT,
    ST_WIT,
    ST_EXP_MUL,
    ST_EXP_SQR,
    ST_EXP_NEXT,
    ST_CHECK,
    ST_SQ_LOOP,
    ST_DONE
  } mrpt_state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_START
  } mrpt_op_e;

  function automatic logic [3:0] witness_val(input logic [2:0] idx);
    logic [3:0] v;
    v = 4'd2;
    case (idx)
      3'd0: v = 4'd2;
      3'd1: v = 4'd3;
      3'd2: v = 4'd5;
      3'd3: v = 4'd7;
      3'd4: v = 4'd11;
      3'd5: v = 4'd13;
      default: v = 4'd2;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/mrpt_stream_if.sv
`timescale 1ns / 1ps
interface mrpt_stream_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/mrpt_mulmod.sv
`timescale 1ns / 1ps
// Shift-and-add modular multiplier: one bit of b per cycle, MSB first.
module mrpt_mulmod
  import mrpt_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] n_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] p_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    acc_q, acc_d, a_q, b_q, b_d, n_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W:0]      dbl, dbl_r, add, add_r;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    add   = dbl_r + {1'b0, a_q};
    add_r = (add >= {1'b0, n_q}) ? add - {1'b0, n_q} : add;
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      b_d    = b_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = b_q[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    if (start_i) begin
      a_q <= a_i;
      n_q <= n_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

### rtl/core/miller_rabin_primality_test.sv
`timescale 1ns / 1ps
// Deterministic Miller-Rabin primality test, witnesses 2,3,5,7,11,13.
// Input channel cand_i carries a 32-bit candidate word; output channel
// res_o carries a 1-bit word, 1 when the candidate is prime.
// Bits of the candidate at NUM_WIDTH and above are ignored.
// One candidate is in work at a time; cand_i.ready is high only when idle.
// Values below 2 and the small primes skip the remainder pass. Small-prime
// residues are found by a remainder pass that takes 4 bits per cycle, and
// multiples of the small primes finish when that pass ends.
// Full tests use one shared shift-and-add modular multiplier; each witness
// needs up to about 2*NUM_WIDTH products.
// The result waits in an output register until res_o.ready; the next
// candidate is taken once the result is gone.
// Reset clears the sequencer and drops any pending result.
module miller_rabin_primality_test
  import mrpt_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mrpt_stream_if.sink   cand_i,
  mrpt_stream_if.source res_o
);
  localparam int unsigned W = NUM_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);
  localparam int unsigned InW = (W < CandWidth) ? W : CandWidth;
  localparam int unsigned NibW = (W + 3) / 4;
  localparam int unsigned RshW = 4 * NibW;

  mrpt_state_e st_q, st_d;
  logic [W-1:0] n_q, d_q, e_q, x_q, sq_q, nm1;
  logic [CW-1:0] r_q, i_q, cnt_q;
  logic [2:0] w_q;
  logic [3:0] rem_q [NumWitnesses];
  logic [3:0] rem_d [NumWitnesses];
  logic [RshW-1:0] rsh_q;
  logic [7:0] rt, pk;
  logic rv_q, rflag_q;
  logic mstart;
  logic [W-1:0] ma, mb;
  logic mdone, mbusy;
  logic [W-1:0] mp;
  logic sel_sq_q;

  assign nm1 = n_q - 1'b1;

  mrpt_mulmod #(.W(W)) u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .n_i(n_q),
    .busy_o(mbusy), .done_o(mdone), .p_o(mp)
  );

  assign cand_i.ready = (st_q == ST_IDLE) && !rv_q;
  assign res_o.valid  = rv_q;
  assign res_o.data   = rflag_q;

  logic any_zero, any_eq;
  always_comb begin
    any_zero = 1'b0;
    any_eq   = 1'b0;
    for (int k = 0; k < NumWitnesses; k++) begin
      if (rem_q[k] == 4'd0) any_zero = 1'b1;
      if (n_q == W'(witness_val(3'(k)))) any_eq = 1'b1;
    end
  end

  // Fold the next nibble into each residue: restoring reduction of rem*16+nib.
  always_comb begin
    rt = '0;
    pk = '0;
    for (int k = 0; k < NumWitnesses; k++) begin
      pk = 8'(witness_val(3'(k)));
      rt = {rem_q[k], rsh_q[RshW-1 -: 4]};
      for (int s = 3; s >= 0; s--) begin
        if (rt >= (pk << s)) rt = rt - (pk << s);
      end
      rem_d[k] = rt[3:0];
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:     if (cand_i.valid && cand_i.ready) st_d = ST_SMALL;
      ST_SMALL: begin
        if (n_q < W'(2) || any_eq) st_d = ST_DONE;
        else if (cnt_q == '0) st_d = any_zero ? ST_DONE : ST_SPLIT;
      end
      ST_SPLIT:    if (d_q[0]) st_d = ST_WIT;
      ST_WIT:      st_d = ST_EXP_NEXT;
      ST_EXP_NEXT: begin
        if (e_q == '0) st_d = ST_CHECK;
        else st_d = e_q[0] ? ST_EXP_MUL : ST_EXP_SQR;
      end
      ST_EXP_MUL:  if (mdone) st_d = ST_EXP_SQR;
      ST_EXP_SQR:  if (mdone) st_d = ST_EXP_NEXT;
      ST_CHECK: begin
        if (x_q == W'(1) || x_q == nm1)
          st_d = (w_q == 3'(NumWitnesses - 1)) ? ST_DONE : ST_WIT;
        else if (i_q + CW'(1) >= r_q) st_d = ST_DONE;
        else st_d = ST_SQ_LOOP;
      end
      ST_SQ_LOOP: begin
        if (mdone) begin
          if (mp == nm1)
            st_d = (w_q == 3'(NumWitnesses - 1)) ? ST_DONE : ST_WIT;
          else if (i_q + CW'(2) >= r_q) st_d = ST_DONE;
        end
      end
      ST_DONE:     st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  // Multiplier launch: start on entry to a multiply state.
  always_comb begin
    mstart = 1'b0;
    ma = x_q;
    mb = sq_q;
    case (st_q)
      ST_EXP_MUL: begin
        mstart = !mbusy && !mdone && !sel_sq_q;
        ma = x_q; mb = sq_q;
      end
      ST_EXP_SQR: begin
        mstart = !mbusy && !mdone && !sel_sq_q;
        ma = sq_q; mb = sq_q;
      end
      ST_SQ_LOOP: begin
        mstart = !mbusy && !mdone && !sel_sq_q;
        ma = x_q; mb = x_q;
      end
      default: mstart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      rv_q     <= 1'b0;
      sel_sq_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (res_o.valid && res_o.ready) rv_q <= 1'b0;
      if (st_q == ST_DONE) rv_q <= 1'b1;
      // mark launched so a multiply state starts only once
      if (mstart) sel_sq_q <= 1'b1;
      else if (mdone) sel_sq_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (cand_i.valid && cand_i.ready) begin
          n_q <= W'(cand_i.data[InW-1:0]);
          rsh_q <= RshW'(cand_i.data[InW-1:0]);
          cnt_q <= CW'(NibW);
          for (int k = 0; k < NumWitnesses; k++) rem_q[k] <= 4'd0;
        end
      end
      ST_SMALL: begin
        if (n_q < W'(2)) rflag_q <= 1'b0;
        else if (any_eq) rflag_q <= 1'b1;
        else if (cnt_q == '0) rflag_q <= 1'b0;
        if (cnt_q != '0) begin
          // residues, one nibble per cycle, MSB first
          for (int k = 0; k < NumWitnesses; k++) rem_q[k] <= rem_d[k];
          rsh_q <= rsh_q << 4;
          cnt_q <= cnt_q - 1'b1;
        end
        d_q <= nm1;
        r_q <= '0;
        w_q <= 3'd7;
      end
      ST_SPLIT: begin
        if (!d_q[0]) begin
          d_q <= d_q >> 1;
          r_q <= r_q + 1'b1;
        end
      end
      ST_WIT: begin
        w_q  <= w_q + 1'b1;
        x_q  <= W'(1);
        sq_q <= W'(witness_val(w_q + 3'd1));
        e_q  <= d_q;
        i_q  <= '0;
      end
      ST_EXP_MUL: if (mdone) x_q <= mp;
      ST_EXP_SQR: begin
        if (mdone) begin
          sq_q <= mp;
          e_q  <= e_q >> 1;
        end
      end
      ST_CHECK: begin
        if (x_q == W'(1) || x_q == nm1) begin
          if (w_q == 3'(NumWitnesses - 1)) rflag_q <= 1'b1;
        end else if (i_q + CW'(1) >= r_q) rflag_q <= 1'b0;
      end
      ST_SQ_LOOP: begin
        if (mdone) begin
          x_q <= mp;
          i_q <= i_q + 1'b1;
          if (mp == nm1) begin
            if (w_q == 3'(NumWitnesses - 1)) rflag_q <= 1'b1;
          end else if (i_q + CW'(2) >= r_q) rflag_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end
endmodule
